// ===== hdl/clipped_rect_fill_shade_engine_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill and shade engine
// Implication checks on the rising clock edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_RECT_FILL_SHADE_ENGINE_ASSERT_SVH
`define CLIPPED_RECT_FILL_SHADE_ENGINE_ASSERT_SVH

// same-cycle implication
`define CRFS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crfs check failed");

// next-cycle implication
`define CRFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crfs check failed");

`endif

// ===== hdl/crfs_pkg.sv =====
// ---------------------------------------------------------------------------
// crfs_pkg
// Types, codes and constants shared by the fill and shade engine modules.
// ---------------------------------------------------------------------------
package crfs_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // operation codes
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_FILL   = 3'd2;
  localparam logic [2:0] OP_DARKEN = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CLIP_LEFT     = 3'd2;
  localparam logic [2:0] REG_CLIP_TOP      = 3'd3;
  localparam logic [2:0] REG_CLIP_RIGHT    = 3'd4;
  localparam logic [2:0] REG_CLIP_BOTTOM   = 3'd5;

  localparam logic [7:0]         SCREEN_RESET = 8'd128;
  localparam logic signed [15:0] CLIP_MAX     = 16'sh7fff;
  localparam logic [6:0]         FULL_PCT     = 7'd100;
  localparam logic [14:0]        COUNT_MAX    = 15'h7fff;
  // floor(v / 100) == (v * RECIP_K) >> RECIP_SHIFT for v <= 25500
  localparam logic [12:0]        RECIP_K      = 13'd5243;
  localparam int                 RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [31:0]        color;
    logic [6:0]         percent;
  } cmd_t;

  typedef struct packed {
    logic [23:0] read_pixel;
    logic [14:0] pixels_written;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic bound;
    logic prep;
    logic rd_en;
    logic wr_en;
    logic wr_dark;
    logic mul;
    logic div;
    logic capture;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       last;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_PREP,
    ST_FILL,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_DK_RD,
    ST_DK_MUL,
    ST_DK_DIV,
    ST_DK_WR,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/crfs_ram.sv =====
// ---------------------------------------------------------------------------
// crfs_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module crfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/crfs_ctrl.sv =====
// ---------------------------------------------------------------------------
// crfs_ctrl
// Command sequencer: bounds, setup, then per-pixel fill, read or darken.
// ---------------------------------------------------------------------------
module crfs_ctrl
  import crfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy,
  output logic  done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: begin
        ctl.bound  = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        ctl.prep = 1'b1;
        if (stat.empty) begin
          state_next = ST_DONE;
        end else if (stat.op inside {OP_WRITE, OP_FILL, OP_CLEAR}) begin
          state_next = ST_FILL;
        end else if (stat.op == OP_READ) begin
          state_next = ST_RD_ISSUE;
        end else if (stat.op == OP_DARKEN) begin
          state_next = ST_DK_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        ctl.wr_en = 1'b1;
        if (stat.last) begin
          state_next = ST_DONE;
        end
      end
      ST_RD_ISSUE: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        ctl.capture = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DK_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_DK_MUL;
      end
      ST_DK_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_DK_DIV;
      end
      ST_DK_DIV: begin
        ctl.div    = 1'b1;
        state_next = ST_DK_WR;
      end
      ST_DK_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_dark = 1'b1;
        state_next  = stat.last ? ST_DONE : ST_DK_RD;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/crfs_datapath.sv =====
// ---------------------------------------------------------------------------
// crfs_datapath
// Config registers, rectangle cutting, raster walker, darken arithmetic and
// the pixel store.
// ---------------------------------------------------------------------------
module crfs_datapath
  import crfs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  input  ctl_t        ctl,
  output stat_t       stat,
  output result_t     result
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW_LIM = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int SH_LIM = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int CW     = $clog2(SW_LIM + 1);
  localparam int RW     = $clog2(SH_LIM + 1);
  localparam int BW     = RW + 9;

  function automatic logic signed [17:0] max3(input logic signed [17:0] a,
                                              input logic signed [17:0] b,
                                              input logic signed [17:0] c);
    logic signed [17:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [17:0] min3(input logic signed [17:0] a,
                                              input logic signed [17:0] b,
                                              input logic signed [17:0] c);
    logic signed [17:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // configuration
  logic [7:0]         screen_width;
  logic [7:0]         screen_height;
  logic signed [15:0] clip_left;
  logic signed [15:0] clip_top;
  logic signed [15:0] clip_right;
  logic signed [15:0] clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_RESET;
      screen_height <= SCREEN_RESET;
      clip_left     <= '0;
      clip_top      <= '0;
      clip_right    <= CLIP_MAX;
      clip_bottom   <= CLIP_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[7:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[7:0];
        REG_CLIP_LEFT:     clip_left     <= cfg_data;
        REG_CLIP_TOP:      clip_top      <= cfg_data;
        REG_CLIP_RIGHT:    clip_right    <= cfg_data;
        REG_CLIP_BOTTOM:   clip_bottom   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [7:0] sw_eff;
  logic [7:0] sh_eff;

  assign sw_eff = (32'(screen_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : screen_width;
  assign sh_eff = (32'(screen_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : screen_height;

  // latched request; single pixels become 1x1 rects, clear the whole screen
  logic [2:0]         op_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic signed [15:0] w_q;
  logic signed [15:0] h_q;
  logic [31:0]        color_q;
  logic [6:0]         pct_q;
  logic               single;
  logic               whole;

  assign single = (cmd.operation == OP_WRITE) || (cmd.operation == OP_READ);
  assign whole  = (cmd.operation == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_q    <= cmd.operation;
      x_q     <= whole ? 16'sd0 : cmd.x_pos;
      y_q     <= whole ? 16'sd0 : cmd.y_pos;
      w_q     <= single ? 16'sd1 : (whole ? signed'({8'd0, sw_eff}) : cmd.rect_width);
      h_q     <= single ? 16'sd1 : (whole ? signed'({8'd0, sh_eff}) : cmd.rect_height);
      color_q <= cmd.color;
      pct_q   <= (cmd.percent > FULL_PCT) ? FULL_PCT : cmd.percent;
    end
  end

  // cut to screen, then to clip (reads and clear ignore the clip)
  logic               noclip;
  logic signed [17:0] sw_s;
  logic signed [17:0] sh_s;
  logic signed [17:0] x0;
  logic signed [17:0] x1;
  logic signed [17:0] y0;
  logic signed [17:0] y1;

  assign noclip = (op_q == OP_READ) || (op_q == OP_CLEAR);
  assign sw_s   = signed'({10'd0, sw_eff});
  assign sh_s   = signed'({10'd0, sh_eff});

  always_ff @(posedge clk) begin
    if (ctl.bound) begin
      x0 <= max3(18'(x_q), 18'sd0, noclip ? 18'sd0 : 18'(clip_left));
      y0 <= max3(18'(y_q), 18'sd0, noclip ? 18'sd0 : 18'(clip_top));
      x1 <= min3(18'(x_q) + 18'(w_q), sw_s, noclip ? sw_s : 18'(clip_right));
      y1 <= min3(18'(y_q) + 18'(h_q), sh_s, noclip ? sh_s : 18'(clip_bottom));
    end
  end

  // raster walker
  logic [CW-1:0] cols;
  logic [CW-1:0] col_left;
  logic [RW-1:0] row_left;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] addr;
  logic [BW-1:0] base;
  logic [AW-1:0] row_next;

  assign base     = BW'(y0[RW-1:0]) * BW'(sw_eff) + BW'(x0[CW-1:0]);
  assign row_next = row_addr + AW'(sw_eff);

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      cols     <= CW'(x1 - x0);
      col_left <= CW'(x1 - x0);
      row_left <= RW'(y1 - y0);
      row_addr <= AW'(base);
      addr     <= AW'(base);
    end else if (ctl.wr_en) begin
      if (col_left == CW'(1)) begin
        row_addr <= row_next;
        addr     <= row_next;
        col_left <= cols;
        row_left <= row_left - RW'(1);
      end else begin
        addr     <= addr + AW'(1);
        col_left <= col_left - CW'(1);
      end
    end
  end

  assign stat.op    = op_q;
  assign stat.empty = !((x1 > x0) && (y1 > y0));
  assign stat.last  = (col_left == CW'(1)) && (row_left == RW'(1));

  // pixel store
  logic [31:0] rd_data;
  logic [31:0] wr_data;
  logic [7:0]  dq [3];

  assign wr_data = ctl.wr_dark ? {8'd0, dq[2], dq[1], dq[0]} : color_q;

  crfs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // darken: channel * pct, then divide by 100 through the reciprocal
  logic [14:0] prod [3];
  logic [27:0] quot [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot[k] = 28'(prod[k]) * 28'(RECIP_K);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ctl.mul) begin
        prod[k] <= 15'(rd_data[8*k +: 8]) * 15'(pct_q);
      end
      if (ctl.div) begin
        dq[k] <= quot[k][RECIP_SHIFT +: 8];
      end
    end
  end

  // result
  logic [23:0] read_q;
  logic [14:0] count_q;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      read_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctl.capture) begin
        read_q <= rd_data[23:0];
      end
      if (ctl.wr_en && (count_q != COUNT_MAX)) begin
        count_q <= count_q + 15'd1;
      end
    end
  end

  assign result.read_pixel     = read_q;
  assign result.pixels_written = count_q;

endmodule

// ===== hdl/clipped_rect_fill_shade_engine.sv =====
// ---------------------------------------------------------------------------
// clipped_rect_fill_shade_engine
// 2D pixel engine: write, read, fill, darken and clear over an internal
// store, with rectangles cut to the screen and the clip rectangle.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start / busy            cmd    (cmd_t)
//  result    done (one-cycle strobe) result (result_t)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  A request is latched, cut to the screen and the clip, and set up. Write,
//  fill and clear then write each pixel; darken reads, multiplies, divides
//  and writes back each pixel in turn; a read issues and captures a pixel.
//  Reset (rst, synchronous) restores config and state; store contents stay
//  undefined until written. busy stays high until the result strobe.
//  cfg_ready is low while busy and while a request is offered.
// ---------------------------------------------------------------------------
`include "clipped_rect_fill_shade_engine_assert.svh"

module clipped_rect_fill_shade_engine
  import crfs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = !busy && !start;

  crfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  crfs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .result    (result)
  );

  `CRFS_ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  `CRFS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CRFS_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  `CRFS_ASSERT_IMPL(a_rd_no_wr, clk, rst, done && |result.read_pixel, ~|result.pixels_written)

endmodule
